>>> design/msi_pkg.sv
package msi_pkg;

    // field and register widths
    localparam int ANGLE_W    = 12;
    localparam int DIFF_W     = ANGLE_W + 1;
    localparam int STEPS_W    = 16;
    localparam int HIGH_W     = 11;
    localparam int PULSE_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // pulse mapping datapath widths
    localparam int COEF_W     = 11;
    localparam int MAP_DEN_W  = 12;
    localparam int MAP_A_W    = 14;
    localparam int PROD1_W    = 26;
    localparam int PROD2_W    = COEF_W + MAP_DEN_W;

    // serial divider widths: numerator covers the mapping numerator,
    // divisor covers the step count
    localparam int DIV_NUM_W  = 23;
    localparam int DIV_DEN_W  = STEPS_W;

    localparam int AXES_DEFAULT = 4;
    localparam int IO_AXES      = 4;

    // item modes
    localparam logic MODE_TARGET = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // register index map
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT_BASE = 3'd4;

    localparam int signed LOW_LIMIT_RESET  = -900;
    localparam int        HIGH_LIMIT_RESET = 900;

    // per-axis pulse triples in microseconds
    localparam int PULSE_MIN [4] = '{1303, 1000, 1000, 1000};
    localparam int PULSE_MID [4] = '{1412, 1426, 1458, 1300};
    localparam int PULSE_MAX [4] = '{1534, 1900, 2000, 1600};

    // slope of the segment below angle zero
    function automatic logic [COEF_W-1:0] slope_low(input logic [1:0] k);
        return COEF_W'(PULSE_MID[k] - PULSE_MIN[k]);
    endfunction

    // slope of the segment above angle zero
    function automatic logic [COEF_W-1:0] slope_high(input logic [1:0] k);
        return COEF_W'(PULSE_MAX[k] - PULSE_MID[k]);
    endfunction

    // offset pulse of the segment below angle zero
    function automatic logic [COEF_W-1:0] base_low(input logic [1:0] k);
        return COEF_W'(PULSE_MIN[k]);
    endfunction

    // offset pulse of the segment above angle zero
    function automatic logic [COEF_W-1:0] base_high(input logic [1:0] k);
        return COEF_W'(PULSE_MID[k]);
    endfunction

endpackage

>>> design/msi_in_if.sv
interface msi_in_if
    import msi_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic signed [ANGLE_W-1:0] target_angle0;
    logic signed [ANGLE_W-1:0] target_angle1;
    logic signed [ANGLE_W-1:0] target_angle2;
    logic signed [ANGLE_W-1:0] target_angle3;
    logic [STEPS_W-1:0]        move_steps;

    modport source
    (
        output valid, mode, target_angle0, target_angle1, target_angle2, target_angle3,
        output move_steps,
        input  ready
    );

    modport sink
    (
        input  valid, mode, target_angle0, target_angle1, target_angle2, target_angle3,
        input  move_steps,
        output ready
    );
endinterface

>>> design/msi_out_if.sv
interface msi_out_if
    import msi_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] pulse_axis0;
    logic [PULSE_W-1:0] pulse_axis1;
    logic [PULSE_W-1:0] pulse_axis2;
    logic [PULSE_W-1:0] pulse_axis3;
    logic               moved;
    logic               done_res;

    modport source
    (
        output valid, pulse_axis0, pulse_axis1, pulse_axis2, pulse_axis3, moved, done_res,
        input  ready
    );

    modport sink
    (
        input  valid, pulse_axis0, pulse_axis1, pulse_axis2, pulse_axis3, moved, done_res,
        output ready
    );
endinterface

>>> design/msi_div.sv
module msi_div
    import msi_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] shift_reg;
    logic [NUM_W-1:0] shift_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] den_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             fits;

    // one restoring step: numerator bits shift out at the top, quotient bits in at the bottom
    assign trial     = {rem_reg, shift_reg[NUM_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign fits      = (trial >= {1'b0, den_reg});

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        if (start)
        begin
            shift_next = num;
            rem_next   = '0;
            den_next   = den;
            cnt_next   = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            shift_next = {shift_reg[NUM_W-2:0], fits};
            rem_next   = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next   = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
            den_reg   <= den_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quo  = shift_reg;

endmodule

>>> design/multi_axis_servo_interpolator_core.sv
// Multi-axis servo interpolator. A target beat (mode 0) stores the goal angles and the step
// count and returns nothing. A tick beat (mode 1) moves every axis one interpolation step
// toward its goal and returns the four pulse widths with the moved and done flags. A tick
// goes through the diff, interpolation divide, update, mapping and mapping divide states to
// the finish state; the interpolation divide runs only when the axes differ with more than
// one step left. Each axis has a bit-serial restoring divider for the interpolation and then
// the pulse mapping quotient. One tick is in flight at a time; its result sits in an output
// register, so the next beat is taken while the result waits. Limit registers must be written
// through the plain write port while no tick is in flight; the block does not enforce it.
module multi_axis_servo_interpolator_core
    import msi_pkg::*;
#(
    parameter int AXES = AXES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  write_en,
    input  logic [CFG_IDX_W-1:0]  write_index,
    input  logic [CFG_DATA_W-1:0] write_data,
    msi_in_if.sink                item,
    msi_out_if.source             result
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DIFF,
        ST_IDIV,
        ST_UPD,
        ST_MAPA,
        ST_MAPB,
        ST_MDIV,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration and motion state
    logic signed [ANGLE_W-1:0] low_limit_reg  [4];
    logic signed [ANGLE_W-1:0] low_limit_next [4];
    logic [HIGH_W-1:0]         high_limit_reg  [4];
    logic [HIGH_W-1:0]         high_limit_next [4];
    logic signed [ANGLE_W-1:0] cur_reg  [AXES];
    logic signed [ANGLE_W-1:0] cur_next [AXES];
    logic signed [ANGLE_W-1:0] goal_reg  [AXES];
    logic signed [ANGLE_W-1:0] goal_next [AXES];
    logic [STEPS_W-1:0]        steps_reg;
    logic [STEPS_W-1:0]        steps_next;

    // per-tick working registers
    logic [AXES-1:0]           sign_reg;
    logic [AXES-1:0]           sign_next;
    logic                      differ_reg;
    logic                      differ_next;
    logic                      done_reg;
    logic                      done_next;
    logic signed [PROD1_W-1:0] prod1_reg  [AXES];
    logic signed [PROD1_W-1:0] prod1_next [AXES];
    logic [PROD2_W-1:0]        prod2_reg  [AXES];
    logic [PROD2_W-1:0]        prod2_next [AXES];
    logic [MAP_DEN_W-1:0]      mden_reg  [AXES];
    logic [MAP_DEN_W-1:0]      mden_next [AXES];
    logic [AXES-1:0]           neg_reg;
    logic [AXES-1:0]           neg_next;

    // output register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [PULSE_W-1:0]        pulse_reg  [IO_AXES];
    logic [PULSE_W-1:0]        pulse_next [IO_AXES];
    logic                      moved_reg;
    logic                      moved_next;
    logic                      done_res_reg;
    logic                      done_res_next;

    // per-axis combinational signals
    logic signed [ANGLE_W-1:0] target_in [IO_AXES];
    logic signed [ANGLE_W-1:0] goal_load [AXES];
    logic [AXES-1:0]           ne;
    logic signed [DIFF_W-1:0]  diff_w [AXES];
    logic signed [ANGLE_W-1:0] step_angle [AXES];
    logic signed [PROD1_W-1:0] map_num [AXES];
    logic [PULSE_W-1:0]        sat_pulse [AXES];
    logic [PULSE_W-1:0]        pulse_val [IO_AXES];
    logic [AXES-1:0]           div_busy;
    logic [DIV_NUM_W-1:0]      div_quo [AXES];
    logic                      div_start;
    logic                      div_sel_interp;

    assign target_in[0] = item.target_angle0;
    assign target_in[1] = item.target_angle1;
    assign target_in[2] = item.target_angle2;
    assign target_in[3] = item.target_angle3;

    assign div_sel_interp = (state_reg == ST_DIFF);

    genvar i;
    generate
        for (i = 0; i < AXES; i++)
        begin : g_axis
            localparam logic [1:0] K = 2'(i % 4);

            logic [ANGLE_W-1:0]        abs_diff;
            logic [DIFF_W-1:0]         delta;
            logic signed [DIFF_W-1:0]  sum;
            logic                      p_nonpos;
            logic signed [DIFF_W-1:0]  neg_low;
            logic [MAP_DEN_W-1:0]      den_lo;
            logic [MAP_DEN_W-1:0]      den_hi;
            logic [MAP_DEN_W-1:0]      den_sel;
            logic signed [MAP_A_W-1:0] p_ext;
            logic signed [MAP_A_W-1:0] a;
            logic [COEF_W-1:0]         c1;
            logic [COEF_W-1:0]         c2;
            logic [DIV_NUM_W-1:0]      num_in;
            logic [DIV_DEN_W-1:0]      den_in;

            // goal loaded by a target beat; axes without a field keep goal zero
            if (i < IO_AXES)
            begin : g_goal
                assign goal_load[i] = target_in[i];
            end
            else
            begin : g_goal_zero
                assign goal_load[i] = '0;
            end

            // distance to goal and its magnitude for the interpolation divide
            assign diff_w[i] = {goal_reg[i][ANGLE_W-1], goal_reg[i]}
                             - {cur_reg[i][ANGLE_W-1], cur_reg[i]};
            assign ne[i]     = (cur_reg[i] != goal_reg[i]);
            assign abs_diff  = diff_w[i][DIFF_W-1] ? ANGLE_W'(-diff_w[i])
                                                   : diff_w[i][ANGLE_W-1:0];

            // one interpolation step, quotient truncated toward zero
            assign delta = sign_reg[i] ? (DIFF_W'(0) - {1'b0, div_quo[i][ANGLE_W-1:0]})
                                       : {1'b0, div_quo[i][ANGLE_W-1:0]};
            assign sum   = {cur_reg[i][ANGLE_W-1], cur_reg[i]} + $signed(delta);
            assign step_angle[i] = sum[ANGLE_W-1:0];

            // segment selection and divisor of the pulse mapping
            assign p_nonpos = cur_reg[i][ANGLE_W-1] || (cur_reg[i] == '0);
            assign neg_low  = DIFF_W'(0) - {low_limit_reg[K][ANGLE_W-1], low_limit_reg[K]};
            assign den_lo   = low_limit_reg[K][ANGLE_W-1] ? neg_low[MAP_DEN_W-1:0]
                                                         : MAP_DEN_W'(1);
            assign den_hi   = (high_limit_reg[K] == '0) ? MAP_DEN_W'(1)
                                                        : {1'b0, high_limit_reg[K]};
            assign den_sel  = p_nonpos ? den_lo : den_hi;

            // products of the mapping numerator
            assign p_ext = {{(MAP_A_W - ANGLE_W){cur_reg[i][ANGLE_W-1]}}, cur_reg[i]};
            assign a     = p_nonpos ? (p_ext + $signed({2'b00, den_sel})) : p_ext;
            assign c1    = p_nonpos ? slope_low(K) : slope_high(K);
            assign c2    = p_nonpos ? base_low(K) : base_high(K);
            assign prod1_next[i] = a * $signed({1'b0, c1});
            assign prod2_next[i] = c2 * den_sel;
            assign mden_next[i]  = den_sel;

            assign map_num[i] = prod1_reg[i]
                              + $signed({{(PROD1_W - PROD2_W){1'b0}}, prod2_reg[i]});

            // saturate the mapping quotient; a negative numerator gives zero
            assign sat_pulse[i] = neg_reg[i] ? '0
                                : (|div_quo[i][DIV_NUM_W-1:PULSE_W]) ? {PULSE_W{1'b1}}
                                : div_quo[i][PULSE_W-1:0];

            // divider operands: interpolation in the diff state, mapping otherwise
            assign num_in = div_sel_interp ? DIV_NUM_W'(abs_diff)
                          : (map_num[i][PROD1_W-1] ? '0 : map_num[i][DIV_NUM_W-1:0]);
            assign den_in = div_sel_interp ? steps_reg : DIV_DEN_W'(mden_reg[i]);

            msi_div #(
                .NUM_W (DIV_NUM_W),
                .DEN_W (DIV_DEN_W)
            ) u_div (
                .clk   (clk),
                .rst_n (rst_n),
                .start (div_start),
                .num   (num_in),
                .den   (den_in),
                .busy  (div_busy[i]),
                .quo   (div_quo[i])
            );
        end

        // pulses of axes that have an output field
        for (i = 0; i < IO_AXES; i++)
        begin : g_pulse
            if (i < AXES)
            begin : g_live
                assign pulse_val[i] = sat_pulse[i];
            end
            else
            begin : g_absent
                assign pulse_val[i] = '0;
            end
        end
    endgenerate

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        low_limit_next  = low_limit_reg;
        high_limit_next = high_limit_reg;
        cur_next        = cur_reg;
        goal_next       = goal_reg;
        steps_next      = steps_reg;
        sign_next       = sign_reg;
        differ_next     = differ_reg;
        done_next       = done_reg;
        neg_next        = neg_reg;
        pulse_next      = pulse_reg;
        moved_next      = moved_reg;
        done_res_next   = done_res_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        div_start       = 1'b0;

        // limit register writes
        for (int k = 0; k < 4; k++)
        begin
            if (write_en && (write_index == CFG_LOW_LIMIT_BASE + CFG_IDX_W'(k)))
            begin
                low_limit_next[k] = write_data;
            end
            if (write_en && (write_index == CFG_HIGH_LIMIT_BASE + CFG_IDX_W'(k)))
            begin
                high_limit_next[k] = write_data[HIGH_W-1:0];
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.mode == MODE_TARGET)
                    begin
                        goal_next  = goal_load;
                        steps_next = item.move_steps;
                    end
                    else
                    begin
                        state_next = ST_DIFF;
                    end
                end
            end

            ST_DIFF:
            begin
                differ_next = |ne;
                for (int a = 0; a < AXES; a++)
                begin
                    sign_next[a] = diff_w[a][DIFF_W-1];
                end
                if ((|ne) && (steps_reg > STEPS_W'(1)))
                begin
                    div_start  = 1'b1;
                    state_next = ST_IDIV;
                end
                else
                begin
                    state_next = ST_UPD;
                end
            end

            ST_IDIV:
            begin
                if (!(|div_busy))
                begin
                    state_next = ST_UPD;
                end
            end

            ST_UPD:
            begin
                if (differ_reg)
                begin
                    for (int a = 0; a < AXES; a++)
                    begin
                        cur_next[a] = (steps_reg <= STEPS_W'(1)) ? goal_reg[a] : step_angle[a];
                    end
                    if (steps_reg != '0)
                    begin
                        steps_next = steps_reg - 1'b1;
                    end
                end
                state_next = ST_MAPA;
            end

            ST_MAPA:
            begin
                done_next  = !(|ne);
                state_next = ST_MAPB;
            end

            ST_MAPB:
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    neg_next[a] = map_num[a][PROD1_W-1];
                end
                div_start  = 1'b1;
                state_next = ST_MDIV;
            end

            ST_MDIV:
            begin
                if (!(|div_busy))
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    pulse_next     = pulse_val;
                    moved_next     = differ_reg;
                    done_res_next  = done_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int k = 0; k < 4; k++)
            begin
                low_limit_reg[k]  <= ANGLE_W'(LOW_LIMIT_RESET);
                high_limit_reg[k] <= HIGH_W'(HIGH_LIMIT_RESET);
            end
            for (int a = 0; a < AXES; a++)
            begin
                cur_reg[a]   <= '0;
                goal_reg[a]  <= '0;
                prod1_reg[a] <= '0;
                prod2_reg[a] <= '0;
                mden_reg[a]  <= '0;
            end
            steps_reg     <= '0;
            sign_reg      <= '0;
            differ_reg    <= 1'b0;
            done_reg      <= 1'b0;
            neg_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < IO_AXES; j++)
            begin
                pulse_reg[j] <= '0;
            end
            moved_reg     <= 1'b0;
            done_res_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            low_limit_reg  <= low_limit_next;
            high_limit_reg <= high_limit_next;
            cur_reg        <= cur_next;
            goal_reg       <= goal_next;
            steps_reg      <= steps_next;
            sign_reg       <= sign_next;
            differ_reg     <= differ_next;
            done_reg       <= done_next;
            neg_reg        <= neg_next;
            if (state_reg == ST_MAPA)
            begin
                prod1_reg <= prod1_next;
                prod2_reg <= prod2_next;
                mden_reg  <= mden_next;
            end
            out_valid_reg  <= out_valid_next;
            pulse_reg      <= pulse_next;
            moved_reg      <= moved_next;
            done_res_reg   <= done_res_next;
        end
    end

    // channel ports
    assign item.ready         = (state_reg == ST_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.pulse_axis0 = pulse_reg[0];
    assign result.pulse_axis1 = pulse_reg[1];
    assign result.pulse_axis2 = pulse_reg[2];
    assign result.pulse_axis3 = pulse_reg[3];
    assign result.moved       = moved_reg;
    assign result.done_res    = done_res_reg;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import msi_pkg::*;

    localparam int AXIS_N        = 4;
    localparam int SETTLE_CYCLES = 64;
    localparam int PULSE_TOP     = 4095;
    localparam int IDLE_MAX      = 18;
    localparam int PRINT_CAP     = 100;

    // pulse triples per axis, microseconds
    localparam int US_MIN [4] = '{1303, 1000, 1000, 1000};
    localparam int US_MID [4] = '{1412, 1426, 1458, 1300};
    localparam int US_MAX [4] = '{1534, 1900, 2000, 1600};

    typedef struct packed {
        logic                             mode;
        logic [3:0][ANGLE_W-1:0]          angle;
        logic [STEPS_W-1:0]               steps;
        logic                             drain_first;
    } servo_cmd_t;

    typedef struct packed {
        logic [3:0][PULSE_W-1:0] pulse;
        logic                    moved;
        logic                    done;
    } pulse_beat_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    servo_cmd_t drv_cmd   = '0;
    logic       drv_valid = 1'b0;
    logic       drv_ready = 1'b0;

    msi_in_if  in_bus ();
    msi_out_if out_bus ();

    assign in_bus.valid         = drv_valid;
    assign in_bus.mode          = drv_cmd.mode;
    assign in_bus.target_angle0 = drv_cmd.angle[0];
    assign in_bus.target_angle1 = drv_cmd.angle[1];
    assign in_bus.target_angle2 = drv_cmd.angle[2];
    assign in_bus.target_angle3 = drv_cmd.angle[3];
    assign in_bus.move_steps    = drv_cmd.steps;
    assign out_bus.ready        = drv_ready;

    multi_axis_servo_interpolator_core u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (cfg_we),
        .write_index (cfg_idx),
        .write_data  (cfg_data),
        .item        (in_bus),
        .result      (out_bus)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predicted servo state and limit copies
    int          low_lim  [4] = '{-900, -900, -900, -900};
    int          high_lim [4] = '{900, 900, 900, 900};
    int          cur_pos  [4] = '{0, 0, 0, 0};
    int          goal_pos [4] = '{0, 0, 0, 0};
    int unsigned steps_rem    = 0;

    servo_cmd_t  cmd_queue [$];
    pulse_beat_t pulse_due [$];

    int cmds_queued = 0;
    int cmds_sent   = 0;
    int cmds_taken  = 0;
    int beats_seen  = 0;
    int beats_paced = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int mismatches  = 0;
    bit no_idle     = 1'b0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    function automatic int idle_draw();
        if (no_idle)
            return 0;
        return $urandom_range(0, IDLE_MAX);
    endfunction

    // angle to pulse width, exact integer, truncated then clamped
    function automatic int pulse_for_angle(input int k, input int p);
        longint den;
        longint num;
        longint q;
        if (p <= 0)
        begin
            den = -longint'(low_lim[k]);
            if (den < 1)
                den = 1;
            num = (longint'(p) + den) * (US_MID[k] - US_MIN[k]) + longint'(US_MIN[k]) * den;
        end
        else
        begin
            den = high_lim[k];
            if (den < 1)
                den = 1;
            num = longint'(p) * (US_MAX[k] - US_MID[k]) + longint'(US_MID[k]) * den;
        end
        q = num / den;
        if (q < 0)
            q = 0;
        if (q > PULSE_TOP)
            q = PULSE_TOP;
        return int'(q);
    endfunction

    // advance the predicted state by one accepted beat
    task automatic apply_cmd(input servo_cmd_t c);
        pulse_beat_t b;
        bit          differ;
        bit          settled;
        differ  = 1'b0;
        settled = 1'b1;
        if (c.mode == MODE_TARGET)
        begin
            for (int i = 0; i < AXIS_N; i++)
                goal_pos[i] = int'($signed(c.angle[i]));
            steps_rem = c.steps;
        end
        else
        begin
            for (int i = 0; i < AXIS_N; i++)
                if (cur_pos[i] != goal_pos[i])
                    differ = 1'b1;
            if (differ)
            begin
                for (int i = 0; i < AXIS_N; i++)
                begin
                    if (steps_rem <= 1)
                        cur_pos[i] = goal_pos[i];
                    else
                        cur_pos[i] += (goal_pos[i] - cur_pos[i]) / int'(steps_rem);
                end
                if (steps_rem > 0)
                    steps_rem--;
            end
            for (int i = 0; i < AXIS_N; i++)
            begin
                if (cur_pos[i] != goal_pos[i])
                    settled = 1'b0;
                b.pulse[i] = PULSE_W'(pulse_for_angle(i, cur_pos[i]));
            end
            b.moved = differ;
            b.done  = settled;
            pulse_due.push_back(b);
        end
    endtask

    // input driver: one beat at a time, random gap after each
    always @(negedge clk)
    begin
        if (rst_n && cmds_sent == cmds_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                drv_valid <= 1'b0;
            end
            else if (cmd_queue.size() > 0 &&
                     !(cmd_queue[0].drain_first && pulse_due.size() != 0))
            begin
                drv_cmd   <= cmd_queue.pop_front();
                drv_valid <= 1'b1;
                cmds_sent++;
                gap_left = idle_draw();
            end
            else
                drv_valid <= 1'b0;
        end
    end

    // input monitor: predict on every accepted beat
    always @(posedge clk)
    begin
        if (rst_n && in_bus.valid && in_bus.ready)
        begin
            cmds_taken++;
            apply_cmd(drv_cmd);
        end
    end

    // result ready: random stall after each accepted beat
    always @(negedge clk)
    begin
        if (beats_seen != beats_paced)
        begin
            beats_paced = beats_seen;
            stall_left  = idle_draw();
        end
        if (stall_left > 0)
        begin
            stall_left--;
            drv_ready <= 1'b0;
        end
        else
            drv_ready <= rst_n;
    end

    // result monitor: compare against the oldest predicted pulse set
    always @(posedge clk)
    begin
        pulse_beat_t got;
        pulse_beat_t want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            beats_seen++;
            got.pulse[0] = out_bus.pulse_axis0;
            got.pulse[1] = out_bus.pulse_axis1;
            got.pulse[2] = out_bus.pulse_axis2;
            got.pulse[3] = out_bus.pulse_axis3;
            got.moved    = out_bus.moved;
            got.done     = out_bus.done_res;
            if (pulse_due.size() == 0)
                report_mismatch("result beat with no tick pending");
            else
            begin
                want = pulse_due.pop_front();
                for (int i = 0; i < AXIS_N; i++)
                    if (got.pulse[i] !== want.pulse[i])
                        report_mismatch($sformatf("pulse_axis%0d got %0d want %0d",
                                                  i, got.pulse[i], want.pulse[i]));
                if (got.moved !== want.moved)
                    report_mismatch($sformatf("moved got %b want %b", got.moved, want.moved));
                if (got.done !== want.done)
                    report_mismatch($sformatf("done_res got %b want %b", got.done, want.done));
            end
        end
    end

    task automatic write_reg(input int idx, input int val);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_IDX_W'(idx);
        cfg_data <= data;
        if (idx < CFG_HIGH_LIMIT_BASE)
            low_lim[idx - CFG_LOW_LIMIT_BASE] = int'($signed(data));
        else
            high_lim[idx - CFG_HIGH_LIMIT_BASE] = int'(data[HIGH_W-1:0]);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_limits(input int lo [4], input int hi [4]);
        for (int a = 0; a < AXIS_N; a++)
        begin
            write_reg(CFG_LOW_LIMIT_BASE + a, lo[a]);
            write_reg(CFG_HIGH_LIMIT_BASE + a, hi[a]);
        end
    endtask

    task automatic push_target(input int a0, input int a1, input int a2, input int a3,
                               input int steps);
        servo_cmd_t c;
        c.mode        = MODE_TARGET;
        c.angle[0]    = ANGLE_W'(a0);
        c.angle[1]    = ANGLE_W'(a1);
        c.angle[2]    = ANGLE_W'(a2);
        c.angle[3]    = ANGLE_W'(a3);
        c.steps       = STEPS_W'(steps);
        c.drain_first = ($urandom_range(0, 39) == 0);
        cmd_queue.push_back(c);
        cmds_queued++;
    endtask

    // tick beats carry random payload that the block ignores
    task automatic push_tick();
        servo_cmd_t c;
        c.mode = MODE_TICK;
        for (int i = 0; i < AXIS_N; i++)
            c.angle[i] = ANGLE_W'($urandom_range(0, 4095));
        c.steps       = STEPS_W'($urandom_range(0, 65535));
        c.drain_first = ($urandom_range(0, 39) == 0);
        cmd_queue.push_back(c);
        cmds_queued++;
    endtask

    task automatic wait_idle();
        while (cmd_queue.size() != 0 || cmds_sent != cmds_taken || pulse_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_angle();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return int'($urandom_range(0, 4095)) - 2048;
        if (r == 1)
            return ($urandom_range(0, 1) != 0) ? 1800 : -1800;
        if (r == 2)
            return int'($urandom_range(0, 20)) - 10;
        return int'($urandom_range(0, 3600)) - 1800;
    endfunction

    // mostly short moves, a few long ones
    function automatic int pick_steps();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom_range(0, 65535);
        if (r == 1)
            return 65535;
        return $urandom_range(0, 10);
    endfunction

    task automatic run_random(input int count);
        int goal_n;
        int st;
        int ticks;
        goal_n = cmds_queued + count;
        while (cmds_queued < goal_n)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                // target followed by one tick per step, capped at 12, plus up to 2 more
                st = pick_steps();
                push_target(pick_angle(), pick_angle(), pick_angle(), pick_angle(), st);
                ticks = ((st > 12) ? 12 : st) + $urandom_range(0, 2);
                for (int t = 0; t < ticks; t++)
                    push_tick();
            end
            else if ($urandom_range(0, 1) != 0)
                push_tick();
            else
                push_target(pick_angle(), pick_angle(), pick_angle(), pick_angle(),
                            pick_steps());
        end
    endtask

    task automatic random_limits();
        int lo [4];
        int hi [4];
        for (int a = 0; a < AXIS_N; a++)
        begin
            lo[a] = -int'($urandom_range(1, 1800));
            hi[a] = $urandom_range(1, 1800);
        end
        set_limits(lo, hi);
    endtask

    // stimulus
    initial
    begin
        int lo [4];
        int hi [4];

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: idle tick, jumps, long and short moves, extremes
        push_tick();
        push_target(1800, 1800, 1800, 1800, 0);
        cmd_queue[cmd_queue.size() - 1].drain_first = 1'b1;
        push_tick();
        push_tick();
        push_target(-1800, -1800, -1800, -1800, 1);
        push_tick();
        push_target(1800, -1800, 0, -1, 65535);
        push_tick();
        push_tick();
        push_target(2047, -2048, 2047, -2048, 3);
        repeat (4) push_tick();
        cmd_queue[cmd_queue.size() - 1].drain_first = 1'b1;
        // target equal to the current position: tick has nothing to do
        push_target(2047, -2048, 2047, -2048, 5);
        push_tick();
        push_target(0, 1, -1, 100, 2);
        repeat (3) push_tick();
        push_target(-1, -1, -1, -1, 16'hAAAA);
        push_tick();
        push_target(1365, -1366, 682, -683, 16'h5555);
        push_tick();
        wait_idle();

        // random limits
        random_limits();
        run_random(130);
        wait_idle();

        // widest limits, no idling on either side
        lo = '{-1800, -1800, -1800, -1800};
        hi = '{1800, 1800, 1800, 1800};
        set_limits(lo, hi);
        no_idle = 1'b1;
        run_random(110);
        wait_idle();
        no_idle = 1'b0;

        // narrowest limits
        lo = '{-1, -1, -1, -1};
        hi = '{1, 1, 1, 1};
        set_limits(lo, hi);
        run_random(110);
        wait_idle();

        // low limit not negative, high limit zero, full 12 bit writes
        lo = '{0, 5, 2047, -2048};
        hi = '{0, 4095, 1, 2048};
        set_limits(lo, hi);
        push_target(-5, 3, -2048, 2047, 0);
        push_tick();
        push_target(7, -7, 1, -1, 0);
        push_tick();
        run_random(100);
        wait_idle();

        // random limits again
        random_limits();
        run_random(170);
        wait_idle();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
